// ----- hdl/xcdd_pkg.sv -----
package xcdd_pkg;

    localparam int LINE_BITS   = 16;
    localparam int MAX_RES     = 9;
    localparam int CNT_BITS    = $clog2(MAX_RES + 1);
    localparam int OUT_FIELD_W = 8 + 3 + LINE_BITS;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [3:0] {
        MODE_TEXT,
        MODE_PFX_ANY,
        MODE_PFX_CMT,
        MODE_PFX_CDT,
        MODE_COMMENT,
        MODE_CDASH1,
        MODE_CDASH2,
        MODE_CDATA,
        MODE_ENT_START,
        MODE_ENT_NAMED,
        MODE_ENT_HASH,
        MODE_ENT_DEC,
        MODE_ENT_HEX,
        MODE_DONE
    } mode_t;

    // result kinds
    localparam logic [1:0] KIND_TEXT = 2'd0;
    localparam logic [1:0] KIND_BACK = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;
    localparam logic [1:0] KIND_FIN  = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_ENTITY   = 3'd1;
    localparam logic [2:0] ERR_CDATA    = 3'd2;
    localparam logic [2:0] ERR_COMMENT  = 3'd3;
    localparam logic [2:0] ERR_DBL_DASH = 3'd4;

    // characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_EXCL  = 8'h21;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_A  = 8'h66;
    localparam logic [7:0] CH_LG    = 8'h67;
    localparam logic [7:0] CH_LL    = 8'h6C;
    localparam logic [7:0] CH_LQ    = 8'h71;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] err;
    } res_t;

    // "!--" for comments, "![CDATA[" for CDATA sections
    function automatic logic [7:0] pfx_char(input logic cdt, input logic [2:0] i);
        logic [7:0] c;
        if (cdt) begin
            case (i)
                3'd0:    c = CH_EXCL;
                3'd1:    c = CH_LBRK;
                3'd2:    c = 8'h43;
                3'd3:    c = 8'h44;
                3'd4:    c = 8'h41;
                3'd5:    c = 8'h54;
                3'd6:    c = 8'h41;
                default: c = CH_LBRK;
            endcase
        end
        else begin
            case (i)
                3'd0:    c = CH_EXCL;
                default: c = CH_DASH;
            endcase
        end
        return c;
    endfunction

    // entity ids: lt, gt, quot, amp, apos
    function automatic logic [7:0] ent_char(input logic [2:0] id, input logic [1:0] k);
        logic [7:0] c;
        case ({id, k})
            {3'd0, 2'd0}: c = CH_LL;
            {3'd0, 2'd1}: c = 8'h74;
            {3'd1, 2'd0}: c = CH_LG;
            {3'd1, 2'd1}: c = 8'h74;
            {3'd2, 2'd0}: c = CH_LQ;
            {3'd2, 2'd1}: c = 8'h75;
            {3'd2, 2'd2}: c = 8'h6F;
            {3'd2, 2'd3}: c = 8'h74;
            {3'd3, 2'd0}: c = CH_LA;
            {3'd3, 2'd1}: c = 8'h6D;
            {3'd3, 2'd2}: c = 8'h70;
            {3'd4, 2'd0}: c = CH_LA;
            {3'd4, 2'd1}: c = 8'h70;
            {3'd4, 2'd2}: c = 8'h6F;
            {3'd4, 2'd3}: c = 8'h73;
            default:      c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] ent_len(input logic [2:0] id);
        logic [2:0] n;
        case (id)
            3'd0, 3'd1: n = 3'd2;
            3'd3:       n = 3'd3;
            default:    n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] ent_map(input logic [2:0] id);
        logic [7:0] c;
        case (id)
            3'd0:    c = CH_LT;
            3'd1:    c = CH_GT;
            3'd2:    c = CH_QUOT;
            3'd3:    c = CH_AMP;
            default: c = CH_APOS;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/xml_character_data_decoder_top.sv -----
// Results of an accepted byte are registered and appear on the master side in the next cycle.
// One byte per cycle while each byte gives at most one result and m_tready is high; a
// byte giving several results holds the result buffer until they have all transferred, and
// the next byte is taken in the cycle its last result transfers.
// Reset (rst_n low, asynchronous): text mode, line 1, no error, collapse mode,
// result buffer empty.
module xml_character_data_decoder_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,     // preserve_whitespace
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,       // in_byte
    input  logic [1:0]                          s_tuser,       // end_of_text, restart
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [xcdd_pkg::OUT_TDATA_W-1:0]    m_tdata,       // out_byte, error_code,
                                                               // line_number, zero pad
    output logic [1:0]                          m_tuser,       // kind
    output logic                                m_tlast
);

    localparam logic [xcdd_pkg::LINE_BITS-1:0] LINE_MAX = '1;
    localparam logic [xcdd_pkg::LINE_BITS-1:0] LINE_ONE = xcdd_pkg::LINE_BITS'(1);

    // parse state
    xcdd_pkg::mode_t                  mode_reg, mode_next;
    logic [3:0]                       pidx_reg, pidx_next;
    logic [1:0]                       brk_reg, brk_next;
    logic [7:0]                       ev_reg, ev_next;
    logic                             eo_reg, eo_next;
    logic                             ws_reg, ws_next;
    logic [xcdd_pkg::LINE_BITS-1:0]   line_reg, line_next;
    logic                             err_reg, err_next;
    logic                             preserve_reg;

    // result buffer
    xcdd_pkg::res_t                   res_reg  [xcdd_pkg::MAX_RES];
    xcdd_pkg::res_t                   res_next [xcdd_pkg::MAX_RES];
    logic [xcdd_pkg::LINE_BITS-1:0]   rline_reg;
    logic [xcdd_pkg::CNT_BITS-1:0]    cnt_reg, cnt_new;

    // state after a restart request
    xcdd_pkg::mode_t                  m;
    logic [3:0]                       pi;
    logic [1:0]                       bk;
    logic [7:0]                       ev;
    logic                             eo, ws, er;
    logic [xcdd_pkg::LINE_BITS-1:0]   ln;

    logic [7:0]  b;
    logic        eot, rst_req;
    logic        in_fire, out_fire;

    logic        pfx_cdt;
    logic [3:0]  pfx_len, k;
    logic [7:0]  exp_ch;
    logic        pfx_keep, pfx_ok;
    logic        is_ws, is_dig, is_hex_lo, is_hex_up, hex_ok;
    logic [3:0]  dval;
    logic [11:0] prod;
    logic        acc_ovf;
    logic [7:0]  acc_val;
    logic        ent_bad;
    logic [2:0]  id;
    logic        id_bad;
    logic [2:0]  nm_len;
    logic        nm_end;
    logic [2:0]  start_id;
    logic        start_ok;
    logic        clr, go_done;

    assign b       = s_tdata;
    assign eot     = s_tuser[0];
    assign rst_req = s_tuser[1];

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == '0) || ((cnt_reg == xcdd_pkg::CNT_BITS'(1)) && m_tready);

    always_comb
    begin
        if (rst_req)
        begin
            m  = xcdd_pkg::MODE_TEXT;
            pi = '0;
            bk = '0;
            ev = '0;
            eo = 1'b0;
            ws = 1'b0;
            ln = LINE_ONE;
            er = 1'b0;
        end
        else
        begin
            m  = mode_reg;
            pi = pidx_reg;
            bk = brk_reg;
            ev = ev_reg;
            eo = eo_reg;
            ws = ws_reg;
            ln = line_reg;
            er = err_reg;
        end
    end

    // shared decode
    always_comb
    begin
        pfx_cdt   = (m == xcdd_pkg::MODE_PFX_CDT);
        pfx_len   = pfx_cdt ? 4'd8 : 4'd3;
        k         = (pi >= pfx_len) ? (pfx_len - 4'd1) : pi;
        exp_ch    = xcdd_pkg::pfx_char(pfx_cdt, k[2:0]);
        pfx_keep  = ((m == xcdd_pkg::MODE_PFX_ANY) && (k == 4'd0) && (b == xcdd_pkg::CH_EXCL))
                 || ((m == xcdd_pkg::MODE_PFX_ANY) && (k == 4'd1)
                     && ((b == xcdd_pkg::CH_DASH) || (b == xcdd_pkg::CH_LBRK)));
        pfx_ok    = pfx_keep || ((m != xcdd_pkg::MODE_PFX_ANY) && (b == exp_ch));

        is_ws     = b inside {xcdd_pkg::CH_SP, xcdd_pkg::CH_LF, xcdd_pkg::CH_CR,
                              xcdd_pkg::CH_TAB};
        is_dig    = b inside {[xcdd_pkg::CH_0:xcdd_pkg::CH_9]};
        is_hex_lo = b inside {[xcdd_pkg::CH_LA:xcdd_pkg::CH_LF_A]};
        is_hex_up = b inside {[xcdd_pkg::CH_UA:xcdd_pkg::CH_UF]};
        hex_ok    = is_dig || is_hex_lo || is_hex_up;
        if (is_dig)
            dval = 4'(b - xcdd_pkg::CH_0);
        else if (is_hex_lo)
            dval = 4'(b - xcdd_pkg::CH_LA + 8'd10);
        else
            dval = 4'(b - xcdd_pkg::CH_UA + 8'd10);

        // value * base + digit, base is 16 or 10
        if (m == xcdd_pkg::MODE_ENT_HEX)
            prod = {ev, 4'b0000} + {8'b0, dval};
        else
            prod = {1'b0, ev, 3'b000} + {3'b000, ev, 1'b0} + {8'b0, dval};
        acc_ovf = (prod > 12'd255);
        acc_val = acc_ovf ? 8'd255 : prod[7:0];
        ent_bad = eo || (ev == 8'd0) || (ev == 8'd255);

        id      = ev[2:0];
        id_bad  = (ev >= 8'd5);
        nm_len  = xcdd_pkg::ent_len(id);
        nm_end  = (pi >= {1'b0, nm_len});

        start_ok = 1'b1;
        case (b)
            xcdd_pkg::CH_LL: start_id = 3'd0;
            xcdd_pkg::CH_LG: start_id = 3'd1;
            xcdd_pkg::CH_LQ: start_id = 3'd2;
            xcdd_pkg::CH_LA: start_id = 3'd3;
            default:
            begin
                start_id = 3'd5;
                start_ok = 1'b0;
            end
        endcase
    end

    // line count: every LF accepted while not halted and not in a prefix or done mode, saturating
    always_comb
    begin
        line_next = ln;
        if (!er && !eot && (b == xcdd_pkg::CH_LF) && (ln != LINE_MAX)
            && !(m inside {xcdd_pkg::MODE_DONE, xcdd_pkg::MODE_PFX_ANY,
                           xcdd_pkg::MODE_PFX_CMT, xcdd_pkg::MODE_PFX_CDT}))
            line_next = ln + LINE_ONE;
    end

    // next state
    always_comb
    begin
        mode_next = m;
        pidx_next = pi;
        brk_next  = bk;
        ev_next   = ev;
        eo_next   = eo;
        ws_next   = ws;
        err_next  = er;
        clr       = 1'b0;
        go_done   = 1'b0;

        if (!er)
        begin
            case (m)
                xcdd_pkg::MODE_PFX_ANY, xcdd_pkg::MODE_PFX_CMT, xcdd_pkg::MODE_PFX_CDT:
                begin
                    if (eot)
                        clr = 1'b1;
                    else if ((m == xcdd_pkg::MODE_PFX_ANY) && (k == 4'd0)
                             && (b == xcdd_pkg::CH_EXCL))
                        pidx_next = 4'd1;
                    else if ((m == xcdd_pkg::MODE_PFX_ANY) && (k == 4'd1)
                             && (b == xcdd_pkg::CH_DASH))
                    begin
                        mode_next = xcdd_pkg::MODE_PFX_CMT;
                        pidx_next = 4'd2;
                    end
                    else if ((m == xcdd_pkg::MODE_PFX_ANY) && (k == 4'd1)
                             && (b == xcdd_pkg::CH_LBRK))
                    begin
                        mode_next = xcdd_pkg::MODE_PFX_CDT;
                        pidx_next = 4'd2;
                    end
                    else if (pfx_ok)
                    begin
                        if ((k + 4'd1) >= pfx_len)
                        begin
                            mode_next = pfx_cdt ? xcdd_pkg::MODE_CDATA
                                                : xcdd_pkg::MODE_COMMENT;
                            pidx_next = '0;
                            brk_next  = '0;
                        end
                        else
                            pidx_next = k + 4'd1;
                    end
                    else
                    begin
                        clr     = 1'b1;
                        go_done = 1'b1;
                    end
                end
                xcdd_pkg::MODE_DONE:
                begin
                    if (eot)
                        clr = 1'b1;
                end
                xcdd_pkg::MODE_COMMENT, xcdd_pkg::MODE_CDASH1, xcdd_pkg::MODE_CDASH2:
                begin
                    if (eot)
                        err_next = 1'b1;
                    else if (m == xcdd_pkg::MODE_CDASH2)
                    begin
                        if (b != xcdd_pkg::CH_GT)
                            err_next = 1'b1;
                        clr = 1'b1;
                    end
                    else if (b == xcdd_pkg::CH_DASH)
                        mode_next = (m == xcdd_pkg::MODE_COMMENT) ? xcdd_pkg::MODE_CDASH1
                                                                  : xcdd_pkg::MODE_CDASH2;
                    else
                        mode_next = xcdd_pkg::MODE_COMMENT;
                end
                xcdd_pkg::MODE_CDATA:
                begin
                    if (eot)
                        err_next = 1'b1;
                    else if (b == xcdd_pkg::CH_RBRK)
                    begin
                        if (bk < 2'd2)
                            brk_next = bk + 2'd1;
                    end
                    else if ((b == xcdd_pkg::CH_GT) && (bk == 2'd2))
                        clr = 1'b1;
                    else
                        brk_next = '0;
                end
                xcdd_pkg::MODE_ENT_START:
                begin
                    if (eot)
                        err_next = 1'b1;
                    else if (start_ok)
                    begin
                        ev_next   = {5'b0, start_id};
                        pidx_next = 4'd1;
                        mode_next = xcdd_pkg::MODE_ENT_NAMED;
                    end
                    else if (b == xcdd_pkg::CH_HASH)
                        mode_next = xcdd_pkg::MODE_ENT_HASH;
                    else
                        err_next = 1'b1;
                end
                xcdd_pkg::MODE_ENT_NAMED:
                begin
                    if (eot || id_bad)
                        err_next = 1'b1;
                    else if (nm_end)
                    begin
                        if (b != xcdd_pkg::CH_SEMI)
                            err_next = 1'b1;
                        clr = 1'b1;
                    end
                    else if ((id == 3'd3) && (pi == 4'd1) && (b == 8'h70))
                    begin
                        ev_next   = 8'd4;
                        pidx_next = 4'd2;
                    end
                    else if (b == xcdd_pkg::ent_char(id, pi[1:0]))
                        pidx_next = pi + 4'd1;
                    else
                        err_next = 1'b1;
                end
                xcdd_pkg::MODE_ENT_HASH:
                begin
                    if (eot)
                        err_next = 1'b1;
                    else if (b == xcdd_pkg::CH_LX)
                    begin
                        ev_next   = '0;
                        eo_next   = 1'b0;
                        mode_next = xcdd_pkg::MODE_ENT_HEX;
                    end
                    else if (is_dig)
                    begin
                        ev_next   = {4'b0, dval};
                        eo_next   = 1'b0;
                        mode_next = xcdd_pkg::MODE_ENT_DEC;
                    end
                    else
                        err_next = 1'b1;
                end
                xcdd_pkg::MODE_ENT_DEC, xcdd_pkg::MODE_ENT_HEX:
                begin
                    if (eot)
                        err_next = 1'b1;
                    else if (is_dig || ((m == xcdd_pkg::MODE_ENT_HEX) && hex_ok))
                    begin
                        ev_next = acc_val;
                        if (acc_ovf)
                            eo_next = 1'b1;
                    end
                    else if (b == xcdd_pkg::CH_SEMI)
                    begin
                        if (ent_bad)
                            err_next = 1'b1;
                        clr = 1'b1;
                    end
                    else
                        err_next = 1'b1;
                end
                default:
                begin
                    mode_next = xcdd_pkg::MODE_TEXT;
                    if (eot)
                        clr = 1'b1;
                    else if (is_ws)
                    begin
                        if (!preserve_reg)
                            ws_next = 1'b1;
                    end
                    else if (b == xcdd_pkg::CH_LT)
                    begin
                        ws_next   = 1'b0;
                        mode_next = xcdd_pkg::MODE_PFX_ANY;
                        pidx_next = '0;
                    end
                    else if (b == xcdd_pkg::CH_AMP)
                    begin
                        ws_next   = 1'b0;
                        mode_next = xcdd_pkg::MODE_ENT_START;
                        ev_next   = '0;
                        eo_next   = 1'b0;
                        pidx_next = '0;
                    end
                    else
                        ws_next = 1'b0;
                end
            endcase

            if (clr || err_next)
            begin
                mode_next = go_done ? xcdd_pkg::MODE_DONE : xcdd_pkg::MODE_TEXT;
                pidx_next = '0;
                brk_next  = '0;
                ev_next   = '0;
                eo_next   = 1'b0;
                ws_next   = 1'b0;
            end
        end
    end

    // result list for the accepted byte
    always_comb
    begin
        for (int i = 0; i < xcdd_pkg::MAX_RES; i++)
            res_next[i] = '{data: 8'h00, kind: xcdd_pkg::KIND_TEXT, err: xcdd_pkg::ERR_NONE};
        cnt_new = '0;

        if (!er)
        begin
            case (m)
                xcdd_pkg::MODE_PFX_ANY, xcdd_pkg::MODE_PFX_CMT, xcdd_pkg::MODE_PFX_CDT:
                begin
                    if (eot || !pfx_ok)
                    begin
                        // '<', the matched prefix bytes, then the byte or the finish mark
                        res_next[0] = '{data: xcdd_pkg::CH_LT, kind: xcdd_pkg::KIND_BACK,
                                        err: xcdd_pkg::ERR_NONE};
                        for (int i = 0; i < xcdd_pkg::MAX_RES - 2; i++)
                        begin
                            if (4'(i) < k)
                                res_next[i + 1] = '{data: xcdd_pkg::pfx_char(pfx_cdt, 3'(i)),
                                                    kind: xcdd_pkg::KIND_BACK,
                                                    err: xcdd_pkg::ERR_NONE};
                        end
                        if (eot)
                            res_next[k + 4'd1] = '{data: 8'h00, kind: xcdd_pkg::KIND_FIN,
                                                   err: xcdd_pkg::ERR_NONE};
                        else
                            res_next[k + 4'd1] = '{data: b, kind: xcdd_pkg::KIND_BACK,
                                                   err: xcdd_pkg::ERR_NONE};
                        cnt_new = xcdd_pkg::CNT_BITS'(k + 4'd2);
                    end
                end
                xcdd_pkg::MODE_DONE:
                begin
                    res_next[0] = eot ? '{data: 8'h00, kind: xcdd_pkg::KIND_FIN,
                                          err: xcdd_pkg::ERR_NONE}
                                      : '{data: b, kind: xcdd_pkg::KIND_BACK,
                                          err: xcdd_pkg::ERR_NONE};
                    cnt_new = xcdd_pkg::CNT_BITS'(1);
                end
                xcdd_pkg::MODE_COMMENT, xcdd_pkg::MODE_CDASH1, xcdd_pkg::MODE_CDASH2:
                begin
                    if (eot)
                    begin
                        res_next[0] = '{data: 8'h00, kind: xcdd_pkg::KIND_ERR,
                                        err: xcdd_pkg::ERR_COMMENT};
                        cnt_new = xcdd_pkg::CNT_BITS'(1);
                    end
                    else if ((m == xcdd_pkg::MODE_CDASH2) && (b != xcdd_pkg::CH_GT))
                    begin
                        res_next[0] = '{data: 8'h00, kind: xcdd_pkg::KIND_ERR,
                                        err: xcdd_pkg::ERR_DBL_DASH};
                        cnt_new = xcdd_pkg::CNT_BITS'(1);
                    end
                end
                xcdd_pkg::MODE_CDATA:
                begin
                    if (eot)
                    begin
                        res_next[0] = '{data: 8'h00, kind: xcdd_pkg::KIND_ERR,
                                        err: xcdd_pkg::ERR_CDATA};
                        cnt_new = xcdd_pkg::CNT_BITS'(1);
                    end
                    else if (b == xcdd_pkg::CH_RBRK)
                    begin
                        if (bk >= 2'd2)
                        begin
                            res_next[0] = '{data: xcdd_pkg::CH_RBRK, kind: xcdd_pkg::KIND_TEXT,
                                            err: xcdd_pkg::ERR_NONE};
                            cnt_new = xcdd_pkg::CNT_BITS'(1);
                        end
                    end
                    else if (!((b == xcdd_pkg::CH_GT) && (bk == 2'd2)))
                    begin
                        // flush held brackets, then the byte
                        if (bk >= 2'd2)
                        begin
                            res_next[0] = '{data: xcdd_pkg::CH_RBRK, kind: xcdd_pkg::KIND_TEXT,
                                            err: xcdd_pkg::ERR_NONE};
                            res_next[1] = res_next[0];
                            res_next[2] = '{data: b, kind: xcdd_pkg::KIND_TEXT,
                                            err: xcdd_pkg::ERR_NONE};
                            cnt_new = xcdd_pkg::CNT_BITS'(3);
                        end
                        else if (bk == 2'd1)
                        begin
                            res_next[0] = '{data: xcdd_pkg::CH_RBRK, kind: xcdd_pkg::KIND_TEXT,
                                            err: xcdd_pkg::ERR_NONE};
                            res_next[1] = '{data: b, kind: xcdd_pkg::KIND_TEXT,
                                            err: xcdd_pkg::ERR_NONE};
                            cnt_new = xcdd_pkg::CNT_BITS'(2);
                        end
                        else
                        begin
                            res_next[0] = '{data: b, kind: xcdd_pkg::KIND_TEXT,
                                            err: xcdd_pkg::ERR_NONE};
                            cnt_new = xcdd_pkg::CNT_BITS'(1);
                        end
                    end
                end
                xcdd_pkg::MODE_ENT_START, xcdd_pkg::MODE_ENT_NAMED, xcdd_pkg::MODE_ENT_HASH,
                xcdd_pkg::MODE_ENT_DEC, xcdd_pkg::MODE_ENT_HEX:
                begin
                    if (err_next)
                    begin
                        res_next[0] = '{data: 8'h00, kind: xcdd_pkg::KIND_ERR,
                                        err: xcdd_pkg::ERR_ENTITY};
                        cnt_new = xcdd_pkg::CNT_BITS'(1);
                    end
                    else if (clr)
                    begin
                        // entity closed by ';'
                        res_next[0] = '{data: (m == xcdd_pkg::MODE_ENT_NAMED)
                                              ? xcdd_pkg::ent_map(id) : ev,
                                        kind: xcdd_pkg::KIND_TEXT, err: xcdd_pkg::ERR_NONE};
                        cnt_new = xcdd_pkg::CNT_BITS'(1);
                    end
                end
                default:
                begin
                    if (eot)
                    begin
                        res_next[0] = '{data: 8'h00, kind: xcdd_pkg::KIND_FIN,
                                        err: xcdd_pkg::ERR_NONE};
                        cnt_new = xcdd_pkg::CNT_BITS'(1);
                    end
                    else if (is_ws)
                    begin
                        if (preserve_reg)
                        begin
                            res_next[0] = '{data: b, kind: xcdd_pkg::KIND_TEXT,
                                            err: xcdd_pkg::ERR_NONE};
                            cnt_new = xcdd_pkg::CNT_BITS'(1);
                        end
                        else if (!ws)
                        begin
                            res_next[0] = '{data: xcdd_pkg::CH_SP, kind: xcdd_pkg::KIND_TEXT,
                                            err: xcdd_pkg::ERR_NONE};
                            cnt_new = xcdd_pkg::CNT_BITS'(1);
                        end
                    end
                    else if ((b != xcdd_pkg::CH_LT) && (b != xcdd_pkg::CH_AMP))
                    begin
                        res_next[0] = '{data: b, kind: xcdd_pkg::KIND_TEXT,
                                        err: xcdd_pkg::ERR_NONE};
                        cnt_new = xcdd_pkg::CNT_BITS'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= xcdd_pkg::MODE_TEXT;
            pidx_reg     <= '0;
            brk_reg      <= '0;
            ev_reg       <= '0;
            eo_reg       <= 1'b0;
            ws_reg       <= 1'b0;
            line_reg     <= LINE_ONE;
            err_reg      <= 1'b0;
            preserve_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                preserve_reg <= cfg_wdata;
            if (in_fire)
            begin
                mode_reg <= mode_next;
                pidx_reg <= pidx_next;
                brk_reg  <= brk_next;
                ev_reg   <= ev_next;
                eo_reg   <= eo_next;
                ws_reg   <= ws_next;
                line_reg <= line_next;
                err_reg  <= err_next;
                cnt_reg  <= cnt_new;
            end
            else if (out_fire)
                cnt_reg <= cnt_reg - xcdd_pkg::CNT_BITS'(1);
        end
    end

    // result buffer drains from entry 0
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < xcdd_pkg::MAX_RES; i++)
                res_reg[i] <= res_next[i];
            rline_reg <= line_next;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < xcdd_pkg::MAX_RES - 1; i++)
                res_reg[i] <= res_reg[i + 1];
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = (cnt_reg == xcdd_pkg::CNT_BITS'(1));
    assign m_tuser  = res_reg[0].kind;
    assign m_tdata  = xcdd_pkg::OUT_TDATA_W'({rline_reg, res_reg[0].err, res_reg[0].data});

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> s_tready)
        else $error("input stalled with empty result buffer");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= xcdd_pkg::CNT_BITS'(xcdd_pkg::MAX_RES))
        else $error("result count out of range");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && err_reg && !rst_req) |=> (cnt_reg == '0))
        else $error("results produced while halted");

    a_eot_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && eot && (!err_reg || rst_req)) |=> (cnt_reg != '0))
        else $error("end of text gave no result");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line count reached zero");

endmodule
